[rtl/srdz_pkg.sv]
// Shared types and constants for the stick radial dead-zone unit.
package srdz_pkg;

  localparam int unsigned FullScale   = 32767;
  localparam int unsigned ResetRadius = 7849;
  localparam int unsigned DivSteps    = 31;
  localparam int unsigned RootSteps   = 16;
  localparam int unsigned Latency     = 3 + DivSteps + RootSteps + 1;

  localparam logic [29:0] FullSq    = 30'(FullScale * FullScale);
  localparam logic [14:0] FullRad   = 15'(FullScale);
  localparam logic [15:0] OneQ15    = 16'h8000;

  // First phase: direction dividers and the magnitude square root.
  typedef struct packed {
    logic        dz;
    logic        neg_x;
    logic        neg_y;
    logic [14:0] r;
    logic [31:0] s;
    logic        lsb_x;
    logic [31:0] rem_x;
    logic [30:0] q_x;
    logic        lsb_y;
    logic [31:0] rem_y;
    logic [30:0] q_y;
    logic [29:0] pend;
    logic [31:0] n_rem;
    logic [29:0] n_root;
  } ph_a_t;

  // Second phase: direction square roots and the magnitude divider.
  typedef struct packed {
    logic        dz;
    logic        neg_x;
    logic        neg_y;
    logic        d_zero;
    logic [14:0] d;
    logic [31:0] v_x;
    logic [17:0] rem_x;
    logic [15:0] root_x;
    logic [31:0] v_y;
    logic [17:0] rem_y;
    logic [15:0] root_y;
    logic [15:0] n_pend;
    logic [14:0] n_rem;
    logic [15:0] n_q;
  } ph_b_t;

endpackage

[rtl/stick_radial_deadzone_unit.sv]
// Radial dead zone and Q1.15 normalization for one analog stick sample.
//
// Usage: drive stick_x_i / stick_y_i and pulse start; a request is taken at
// every clock edge with start high and busy low. busy never rises, since
// the datapath is a fully pipelined chain that takes one request per cycle.
// Each request yields exactly one result: result_valid_o is high for one
// cycle with norm_magnitude_o, dir_x_o and dir_y_o, in request order.
// Throughput is one sample per cycle; the pipeline holds the 31 one-bit
// steps of the direction dividers, then the 16 steps of the direction
// square roots, behind three front stages (abs, squares, sum and dead-zone
// test) and ahead of one output stage.
// The receiver cannot stall; results are shown once and never held.
// The radius register is written through cfg_valid_i / cfg_ready_o /
// cfg_data_i; cfg_ready_o is always high. Write it only with no request in
// flight. Reset clears all valid bits and loads the radius with 7849.
module stick_radial_deadzone_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] stick_x_i,
  input  logic signed [15:0] stick_y_i,
  output logic               result_valid_o,
  output logic        [15:0] norm_magnitude_o,
  output logic signed [16:0] dir_x_o,
  output logic signed [16:0] dir_y_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic        [14:0] cfg_data_i
);
  import srdz_pkg::*;

  logic        [14:0] radius_q;
  logic               accept;

  logic               s1_valid_q;
  logic        [15:0] s1_ax_q, s1_ay_q;
  logic               s1_nx_q, s1_ny_q;
  logic        [14:0] s1_r_q;

  logic               s2_valid_q;
  logic        [30:0] s2_ax2_q, s2_ay2_q;
  logic        [29:0] s2_rr_q;
  logic               s2_nx_q, s2_ny_q;
  logic        [14:0] s2_r_q;

  logic        [31:0] s_sum;
  logic               s3_valid_q;
  logic        [31:0] s3_s_q;
  logic        [30:0] s3_ax2_q, s3_ay2_q;
  logic        [29:0] s3_sc_q;
  logic               s3_dz_q, s3_nx_q, s3_ny_q;
  logic        [14:0] s3_r_q;

  ph_a_t              a_st [DivSteps+1];
  logic               a_v  [DivSteps+1];
  ph_b_t              b_st [RootSteps+1];
  logic               b_v  [RootSteps+1];

  logic        [29:0] b_num;
  logic               out_valid_q;
  logic        [15:0] out_norm_q;
  logic signed [16:0] out_dx_q, out_dy_q;

  assign accept      = start && !busy;
  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= 15'(ResetRadius);
    end else if (cfg_valid_i && cfg_ready_o) begin
      radius_q <= cfg_data_i;
    end
  end

  // Front end: valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
    end
  end

  assign s_sum = {1'b0, s2_ax2_q} + {1'b0, s2_ay2_q};

  // Front end: take magnitudes, square, sum, clip and test against the radius.
  always_ff @(posedge clk_i) begin
    s1_ax_q  <= stick_x_i[15] ? 16'(~stick_x_i + 16'sd1) : stick_x_i;
    s1_ay_q  <= stick_y_i[15] ? 16'(~stick_y_i + 16'sd1) : stick_y_i;
    s1_nx_q  <= stick_x_i[15];
    s1_ny_q  <= stick_y_i[15];
    s1_r_q   <= radius_q;

    s2_ax2_q <= {15'd0, s1_ax_q} * {15'd0, s1_ax_q};
    s2_ay2_q <= {15'd0, s1_ay_q} * {15'd0, s1_ay_q};
    s2_rr_q  <= {15'd0, s1_r_q} * {15'd0, s1_r_q};
    s2_nx_q  <= s1_nx_q;
    s2_ny_q  <= s1_ny_q;
    s2_r_q   <= s1_r_q;

    s3_s_q   <= s_sum;
    s3_dz_q  <= (s_sum <= {2'b00, s2_rr_q});
    s3_sc_q  <= (s_sum > {2'b00, FullSq}) ? FullSq : s_sum[29:0];
    s3_ax2_q <= s2_ax2_q;
    s3_ay2_q <= s2_ay2_q;
    s3_nx_q  <= s2_nx_q;
    s3_ny_q  <= s2_ny_q;
    s3_r_q   <= s2_r_q;
  end

  // Seed phase A: dividers start on a^2 * 2^30, root on clipped s * 2^30.
  always_comb begin
    a_v[0]         = s3_valid_q;
    a_st[0].dz     = s3_dz_q;
    a_st[0].neg_x  = s3_nx_q;
    a_st[0].neg_y  = s3_ny_q;
    a_st[0].r      = s3_r_q;
    a_st[0].s      = s3_s_q;
    a_st[0].lsb_x  = s3_ax2_q[0];
    a_st[0].rem_x  = {2'b00, s3_ax2_q[30:1]};
    a_st[0].q_x    = '0;
    a_st[0].lsb_y  = s3_ay2_q[0];
    a_st[0].rem_y  = {2'b00, s3_ay2_q[30:1]};
    a_st[0].q_y    = '0;
    a_st[0].pend   = s3_sc_q;
    a_st[0].n_rem  = '0;
    a_st[0].n_root = '0;
  end

  for (genvar j = 0; j < DivSteps; j++) begin : g_pha
    ph_a_t       nxt;
    logic [32:0] tx, ty;
    logic        gx, gy;

    always_comb begin
      nxt       = a_st[j];
      tx        = {a_st[j].rem_x, (j == 0) ? a_st[j].lsb_x : 1'b0};
      ty        = {a_st[j].rem_y, (j == 0) ? a_st[j].lsb_y : 1'b0};
      gx        = tx >= {1'b0, a_st[j].s};
      gy        = ty >= {1'b0, a_st[j].s};
      nxt.rem_x = gx ? 32'(tx - {1'b0, a_st[j].s}) : tx[31:0];
      nxt.rem_y = gy ? 32'(ty - {1'b0, a_st[j].s}) : ty[31:0];
      nxt.q_x   = {a_st[j].q_x[29:0], gx};
      nxt.q_y   = {a_st[j].q_y[29:0], gy};
    end

    if (j < 30) begin : g_root
      ph_a_t       with_root;
      logic [33:0] tn, trial;
      logic        gn;

      always_comb begin
        with_root        = nxt;
        tn               = {a_st[j].n_rem, a_st[j].pend[29:28]};
        trial            = {2'b00, a_st[j].n_root, 2'b01};
        gn               = tn >= trial;
        with_root.n_rem  = gn ? 32'(tn - trial) : tn[31:0];
        with_root.n_root = {a_st[j].n_root[28:0], gn};
        with_root.pend   = {a_st[j].pend[27:0], 2'b00};
      end

      always_ff @(posedge clk_i) begin
        a_st[j+1] <= with_root;
      end
    end else begin : g_hold
      always_ff @(posedge clk_i) begin
        a_st[j+1] <= nxt;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        a_v[j+1] <= 1'b0;
      end else begin
        a_v[j+1] <= a_v[j];
      end
    end
  end

  // Seed phase B: the magnitude numerator drops the radius term.
  assign b_num = 30'(a_st[DivSteps].n_root - {a_st[DivSteps].r, 15'd0});

  always_comb begin
    b_v[0]         = a_v[DivSteps];
    b_st[0].dz     = a_st[DivSteps].dz;
    b_st[0].neg_x  = a_st[DivSteps].neg_x;
    b_st[0].neg_y  = a_st[DivSteps].neg_y;
    b_st[0].d_zero = a_st[DivSteps].r == FullRad;
    b_st[0].d      = FullRad - a_st[DivSteps].r;
    b_st[0].v_x    = {1'b0, a_st[DivSteps].q_x};
    b_st[0].rem_x  = '0;
    b_st[0].root_x = '0;
    b_st[0].v_y    = {1'b0, a_st[DivSteps].q_y};
    b_st[0].rem_y  = '0;
    b_st[0].root_y = '0;
    b_st[0].n_pend = b_num[15:0];
    b_st[0].n_rem  = {1'b0, b_num[29:16]};
    b_st[0].n_q    = '0;
  end

  for (genvar j = 0; j < RootSteps; j++) begin : g_phb
    ph_b_t       nxt;
    logic [19:0] tx, ty, trx, try_v;
    logic [15:0] tn;
    logic        gx, gy, gn;

    always_comb begin
      nxt        = b_st[j];
      tx         = {b_st[j].rem_x, b_st[j].v_x[31:30]};
      ty         = {b_st[j].rem_y, b_st[j].v_y[31:30]};
      trx        = {2'b00, b_st[j].root_x, 2'b01};
      try_v      = {2'b00, b_st[j].root_y, 2'b01};
      gx         = tx >= trx;
      gy         = ty >= try_v;
      nxt.rem_x  = gx ? 18'(tx - trx) : tx[17:0];
      nxt.rem_y  = gy ? 18'(ty - try_v) : ty[17:0];
      nxt.root_x = {b_st[j].root_x[14:0], gx};
      nxt.root_y = {b_st[j].root_y[14:0], gy};
      nxt.v_x    = {b_st[j].v_x[29:0], 2'b00};
      nxt.v_y    = {b_st[j].v_y[29:0], 2'b00};
      tn         = {b_st[j].n_rem, b_st[j].n_pend[15]};
      gn         = tn >= {1'b0, b_st[j].d};
      nxt.n_rem  = gn ? 15'(tn - {1'b0, b_st[j].d}) : tn[14:0];
      nxt.n_q    = {b_st[j].n_q[14:0], gn};
      nxt.n_pend = {b_st[j].n_pend[14:0], 1'b0};
    end

    always_ff @(posedge clk_i) begin
      b_st[j+1] <= nxt;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        b_v[j+1] <= 1'b0;
      end else begin
        b_v[j+1] <= b_v[j];
      end
    end
  end

  // Output stage: zero inside the dead zone, saturate on a zero span, sign.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= b_v[RootSteps];
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_st[RootSteps].dz) begin
      out_norm_q <= '0;
      out_dx_q   <= '0;
      out_dy_q   <= '0;
    end else begin
      out_norm_q <= b_st[RootSteps].d_zero ? OneQ15 : b_st[RootSteps].n_q;
      out_dx_q   <= b_st[RootSteps].neg_x ?
                    17'(~{1'b0, b_st[RootSteps].root_x} + 17'd1) :
                    {1'b0, b_st[RootSteps].root_x};
      out_dy_q   <= b_st[RootSteps].neg_y ?
                    17'(~{1'b0, b_st[RootSteps].root_y} + 17'd1) :
                    {1'b0, b_st[RootSteps].root_y};
    end
  end

  assign result_valid_o   = out_valid_q;
  assign norm_magnitude_o = out_norm_q;
  assign dir_x_o          = out_dx_q;
  assign dir_y_o          = out_dy_q;

  // Every request shows its result after the fixed latency.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##(Latency) result_valid_o)
    else $error("result strobe missing after latency");

  a_norm_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> norm_magnitude_o <= OneQ15)
    else $error("normalized magnitude above one");

  a_dir_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (dir_x_o >= -17'sd32768 && dir_x_o <= 17'sd32768 &&
                        dir_y_o >= -17'sd32768 && dir_y_o <= 17'sd32768))
    else $error("direction out of range");

  a_dead_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && norm_magnitude_o == 16'd0 && !$past(b_st[RootSteps].dz)
     && !$past(b_st[RootSteps].d_zero)) |-> $past(b_st[RootSteps].n_q) == 16'd0)
    else $error("magnitude zero without dead zone");

endmodule

[sim/srdz_checker.sv]
// Result predictor and scoreboard for the stick radial dead-zone unit.
`timescale 1ns / 1ps
module srdz_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  input  logic               busy,
  input  logic signed [15:0] stick_x_i,
  input  logic signed [15:0] stick_y_i,
  input  logic               result_valid_o,
  input  logic        [15:0] norm_magnitude_o,
  input  logic signed [16:0] dir_x_o,
  input  logic signed [16:0] dir_y_o,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_o,
  input  logic        [14:0] cfg_data_i,
  output int                 fail_count,
  output int                 pending_count
);
  import srdz_pkg::*;

  typedef struct packed {
    logic        [15:0] mag;
    logic signed [16:0] dx;
    logic signed [16:0] dy;
  } stick_vec_t;

  stick_vec_t  expected_vecs[$];
  logic [14:0] radius;

  // Largest k <= 32768 with (k*d + 32768*r)^2 <= 2^30 * sc.
  function automatic logic [15:0] scaled_magnitude(longint unsigned d, longint unsigned r,
                                                   longint unsigned sc);
    longint unsigned k, t, lhs;
    k = 0;
    for (int b = 15; b >= 0; b--) begin
      t = k | (64'd1 << b);
      if (t <= OneQ15) begin
        lhs = t * d + 64'd32768 * r;
        if (lhs * lhs <= (sc << 30)) k = t;
      end
    end
    return k[15:0];
  endfunction

  // sign(v) * floor(32768 * |v| / sqrt(s)), found by bitwise search.
  function automatic logic signed [16:0] direction(logic signed [15:0] v, longint unsigned s);
    longint unsigned a, k, t;
    logic [16:0] q;
    a = (v < 0) ? -longint'(v) : longint'(v);
    k = 0;
    for (int b = 15; b >= 0; b--) begin
      t = k | (64'd1 << b);
      if (t <= OneQ15 && t * t * s <= ((a * a) << 30)) k = t;
    end
    q = k[16:0];
    return (v < 0) ? -q : q;
  endfunction

  function automatic stick_vec_t predict_stick(logic signed [15:0] x, logic signed [15:0] y,
                                               logic [14:0] r);
    stick_vec_t      v;
    longint unsigned ax, ay, s, sc, full2;
    ax = (x < 0) ? -longint'(x) : longint'(x);
    ay = (y < 0) ? -longint'(y) : longint'(y);
    s = ax * ax + ay * ay;
    full2 = longint'(FullScale) * FullScale;
    v = '0;
    if (s > longint'(r) * r) begin
      sc = (s > full2) ? full2 : s;
      v.mag = scaled_magnitude(FullScale - r, r, sc);
      v.dx = direction(x, s);
      v.dy = direction(y, s);
    end
    return v;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    stick_vec_t e;
    if (!rst_ni) begin
      radius = 15'(ResetRadius);
      fail_count = 0;
      expected_vecs.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_o) radius = cfg_data_i;
      if (start && !busy) expected_vecs.push_back(predict_stick(stick_x_i, stick_y_i, radius));
      if (result_valid_o) begin
        if (expected_vecs.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result %h %h %h",
                                         norm_magnitude_o, dir_x_o, dir_y_o);
        end else begin
          e = expected_vecs.pop_front();
          if (e.mag !== norm_magnitude_o || e.dx !== dir_x_o || e.dy !== dir_y_o) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: exp mag %0d dx %0d dy %0d, got mag %0d dx %0d dy %0d",
                       e.mag, e.dx, e.dy, norm_magnitude_o, dir_x_o, dir_y_o);
          end
        end
      end
    end
    pending_count = expected_vecs.size();
  end
endmodule

[sim/tb_top.sv]
// Stimulus and verdict for the stick radial dead-zone unit testbench.
`timescale 1ns / 1ps
module tb_top;
  import srdz_pkg::*;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic signed [15:0] stick_x_i = '0;
  logic signed [15:0] stick_y_i = '0;
  logic               result_valid_o;
  logic        [15:0] norm_magnitude_o;
  logic signed [16:0] dir_x_o, dir_y_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic        [14:0] cfg_data_i = '0;
  int                 fail_count, pending_count;
  int                 cycle_count = 0;
  int                 idle_pct;

  always #4 clk_i = ~clk_i;

  stick_radial_deadzone_unit DUT (.*);
  srdz_checker u_checker (.*);

  // Bail out if the pipeline stops returning results.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > 200000) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Issue one request at the falling edge and hold it until taken; start is left high.
  task automatic send_stick(logic signed [15:0] x, logic signed [15:0] y);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
    start <= 1'b1;
    stick_x_i <= x;
    stick_y_i <= y;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Drain the pipeline, then write the radius while idle.
  task automatic set_radius(logic [14:0] r);
    start <= 1'b0;
    @(negedge clk_i);
    while (pending_count != 0) @(negedge clk_i);
    repeat (Latency + 4) @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= r;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Equal mix of full noise, dead-zone edge vectors, full-scale x and diagonals within r + 200.
  task automatic random_sticks(int n, logic [14:0] r);
    int m;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(3))
        0: send_stick(16'($urandom), 16'($urandom));
        1: begin
          m = int'(r) + $urandom_range(6) - 3;
          send_stick(16'($urandom_range(1) ? m : -m), 16'($urandom_range(40) - 20));
        end
        2: send_stick($urandom_range(1) ? 16'sh8000 : 16'sh7fff, 16'($urandom));
        default: begin
          m = $urandom_range(r + 200);
          send_stick(16'($urandom_range(1) ? m : -m), 16'($urandom_range(1) ? m : -m));
        end
      endcase
    end
  endtask

  initial begin
    idle_pct = 0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: center, dead-zone edge at the reset radius, axes, corners.
    send_stick(0, 0);
    send_stick(7849, 0);
    send_stick(7850, 0);
    send_stick(0, -7850);
    send_stick(16'sh7fff, 0);
    send_stick(16'sh8000, 0);
    send_stick(0, 16'sh8000);
    send_stick(16'sh8000, 16'sh8000);
    send_stick(16'sh7fff, 16'sh7fff);
    send_stick(-1, 16'sh7fff);
    send_stick(30000, -20000);
    random_sticks(100, 15'(ResetRadius));

    set_radius(15'd0);
    send_stick(0, 0);
    send_stick(1, 0);
    send_stick(-1, -1);
    idle_pct = 68;
    random_sticks(150, 15'd0);

    set_radius(15'd32766);
    send_stick(16'sh7ffe, 0);
    send_stick(16'sh7fff, 0);
    send_stick(16'sh8000, 0);
    send_stick(16'sh8000, 16'sh8000);
    idle_pct = 21;
    random_sticks(150, 15'd32766);

    set_radius(15'h7fff);
    send_stick(16'sh7fff, 0);
    send_stick(16'sh8000, 0);
    send_stick(16'sh7fff, 1);
    random_sticks(60, 15'h7fff);

    set_radius(15'($urandom_range(32766)));
    idle_pct = 0;
    random_sticks(130, 15'd16384);
    set_radius(15'h5555);
    idle_pct = 68;
    random_sticks(130, 15'h5555);

    start <= 1'b0;
    @(negedge clk_i);
    while (pending_count != 0) @(negedge clk_i);
    repeat (Latency + 4) @(negedge clk_i);
    if (fail_count == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
